[hw/rtl/mre_pkg.sv]
// Shared types, constants and operand tables for the mean reprojection error block.
`timescale 1ns / 1ps
`default_nettype none
package mre_pkg;

  localparam int MAX_CAMERAS_DEF   = 256;
  localparam int MAX_POINTS_DEF    = 16384;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CAM_WORDS = 7;
  localparam int PT_WORDS  = 3;
  localparam int SUM_W     = 48;

  typedef enum logic [1:0] {
    OP_LOAD_CAM = 2'd0,
    OP_LOAD_PT  = 2'd1,
    OP_OBS      = 2'd2,
    OP_FINISH   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         camera_index;
    logic [13:0]        point_index;
    logic [2:0]         component;
    logic signed [31:0] load_value;
    logic signed [31:0] obs_u;
    logic signed [31:0] obs_v;
  } in_item_t;

  typedef struct packed {
    logic [31:0] mean_error;
    logic [31:0] observation_count;
    logic        depth_fault;
    logic        empty_set;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_NONE, ST_FETCH, ST_QMUL, ST_RMAT, ST_PMUL, ST_CSUM, ST_DIVU, ST_DIVV,
    ST_RESID, ST_SQR, ST_SQRT, ST_ACC, ST_FIN, ST_OUT
  } step_t;

  typedef struct packed {
    step_t      step;
    logic [3:0] k;
    logic       go;
  } cmd_t;

  typedef struct packed {
    logic obs_ok;
    logic depth_zero;
    logic count_zero;
    logic div_done;
    logic sqrt_done;
  } status_t;

  // quaternion products in order: yy zz xy wz xz wy xx yz wx (x=0 y=1 z=2 w=3)
  function automatic logic [1:0] qa_sel(input logic [3:0] k);
    case (k)
      4'd0: qa_sel = 2'd1;
      4'd1: qa_sel = 2'd2;
      4'd2: qa_sel = 2'd0;
      4'd3: qa_sel = 2'd3;
      4'd4: qa_sel = 2'd0;
      4'd5: qa_sel = 2'd3;
      4'd6: qa_sel = 2'd0;
      4'd7: qa_sel = 2'd1;
      4'd8: qa_sel = 2'd3;
      default: qa_sel = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] qb_sel(input logic [3:0] k);
    case (k)
      4'd0: qb_sel = 2'd1;
      4'd1: qb_sel = 2'd2;
      4'd2: qb_sel = 2'd1;
      4'd3: qb_sel = 2'd2;
      4'd4: qb_sel = 2'd2;
      4'd5: qb_sel = 2'd1;
      4'd6: qb_sel = 2'd0;
      4'd7: qb_sel = 2'd2;
      4'd8: qb_sel = 2'd0;
      default: qb_sel = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pj_sel(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: pj_sel = 2'd0;
      4'd1, 4'd4, 4'd7: pj_sel = 2'd1;
      4'd2, 4'd5, 4'd8: pj_sel = 2'd2;
      default: pj_sel = 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mre_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mre_div #(
  parameter int NUM_W = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [31:0]      den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [32:0]      shifted;
  logic [33:0]      diff;

  always_comb begin
    shifted  = {rem_r, q_r[NUM_W-1]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[31:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

[hw/rtl/mre_sqrt.sv]
// Bit-pair integer square root of a 64-bit value, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mre_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] rad,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] rad_r, rad_nxt;
  logic [31:0] root_r, root_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [34:0] cand;
  logic [34:0] trial;

  always_comb begin
    cand     = {rem_r[32:0], rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (cand >= trial) begin
        rem_nxt  = 34'(cand - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = cand[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

[hw/rtl/mre_dp.sv]
// Datapath: pose and point stores, shared multiplier, divider, square root, accumulators.
`timescale 1ns / 1ps
`default_nettype none
module mre_dp #(
  parameter int MAX_CAMERAS   = mre_pkg::MAX_CAMERAS_DEF,
  parameter int MAX_POINTS    = mre_pkg::MAX_POINTS_DEF,
  parameter int FRACTION_BITS = mre_pkg::FRACTION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire mre_pkg::in_item_t in_item,
  input  wire mre_pkg::cmd_t     cmd,
  output mre_pkg::status_t       sts,
  output logic                   out_valid,
  output mre_pkg::out_item_t     out_item
);

  localparam int CAM_DEPTH = MAX_CAMERAS * mre_pkg::CAM_WORDS;
  localparam int PT_DEPTH  = MAX_POINTS * mre_pkg::PT_WORDS;
  localparam int CAW       = $clog2(CAM_DEPTH);
  localparam int PAW       = $clog2(PT_DEPTH);
  localparam int QW        = 64 - FRACTION_BITS;
  localparam int SW        = QW + 3;
  localparam int NUM_W     = (32 + FRACTION_BITS > mre_pkg::SUM_W) ?
                             32 + FRACTION_BITS : mre_pkg::SUM_W;
  localparam logic signed [SW-1:0] S32_HI = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] S32_LO = -SW'(64'sd2147483648);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1) <<< FRACTION_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > S32_HI) sat32 = 32'sh7FFF_FFFF;
    else if (v < S32_LO) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) sub_sat = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sub_sat = d[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] a);
    abs32 = a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic logic signed [31:0] proj(input logic [NUM_W-1:0] q, input logic neg);
    logic big;
    big = |q[NUM_W-1:32];
    if (!neg) proj = (big || q[31]) ? 32'sh7FFF_FFFF : q[31:0];
    else proj = (big || (q[31] && |q[30:0])) ? 32'sh8000_0000 : -$signed(q[31:0]);
  endfunction

  // stores
  logic [31:0] cam_mem [CAM_DEPTH];
  logic [31:0] pt_mem  [PT_DEPTH];
  logic [31:0] cam_rd_r, pt_rd_r;
  logic [CAW-1:0] cam_base_r, cam_waddr, cam_raddr;
  logic [PAW-1:0] pt_base_r, pt_waddr, pt_raddr;
  logic cam_ok, pt_ok, cam_we, pt_we, cam_re, pt_re;

  logic       fetch_v_r;
  logic [2:0] fetch_k_r;

  logic signed [31:0]   qq_r [4];
  logic signed [31:0]   tv_r [3];
  logic signed [31:0]   pv_r [3];
  logic signed [QW-1:0] m_r  [9];
  logic signed [31:0]   rm_r [9];
  logic signed [31:0]   cv_r [3];
  logic signed [31:0]   nu_r, nv_r, ru_r, rv_r, obs_u_r, obs_v_r;
  logic [63:0]          sq_r [2];
  logic [31:0]          norm_r, mean_r;

  logic [mre_pkg::SUM_W-1:0] sum_r;
  logic [31:0]               cnt_r;
  logic                      fault_r;
  logic                      out_valid_r;
  mre_pkg::out_item_t        out_r;

  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   prod;
  logic signed [SW-1:0] me [9];
  logic signed [31:0]   rmat_v [9];
  logic signed [31:0]   cs_v [3];

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [31:0]      div_den;
  logic             sqrt_start, sqrt_done;
  logic [31:0]      sqrt_root;
  logic             depth_zero, count_zero;
  logic [31:0]      acc_n;
  logic [mre_pkg::SUM_W:0] sum_ext;

  assign cam_ok = 32'(in_item.camera_index) < 32'(MAX_CAMERAS);
  assign pt_ok  = 32'(in_item.point_index) < 32'(MAX_POINTS);
  assign cam_waddr = CAW'(CAW'(in_item.camera_index) * CAW'(mre_pkg::CAM_WORDS))
                     + CAW'(in_item.component);
  assign pt_waddr  = PAW'(PAW'(in_item.point_index) * PAW'(mre_pkg::PT_WORDS))
                     + PAW'(in_item.component);
  assign cam_we = accept && (in_item.op == mre_pkg::OP_LOAD_CAM) && cam_ok
                  && (in_item.component < 3'(mre_pkg::CAM_WORDS));
  assign pt_we  = accept && (in_item.op == mre_pkg::OP_LOAD_PT) && pt_ok
                  && (in_item.component < 3'(mre_pkg::PT_WORDS));
  assign cam_re = (cmd.step == mre_pkg::ST_FETCH) && (cmd.k < 4'(mre_pkg::CAM_WORDS));
  assign pt_re  = (cmd.step == mre_pkg::ST_FETCH) && (cmd.k < 4'(mre_pkg::PT_WORDS));
  assign cam_raddr = cam_base_r + CAW'(cmd.k);
  assign pt_raddr  = pt_base_r + PAW'(cmd.k);

  always_ff @(posedge clk) begin
    if (cam_we) cam_mem[cam_waddr] <= in_item.load_value;
    if (cam_re) cam_rd_r <= cam_mem[cam_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= in_item.load_value;
    if (pt_re) pt_rd_r <= pt_mem[pt_raddr];
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      mre_pkg::ST_QMUL: begin
        mul_a = qq_r[mre_pkg::qa_sel(cmd.k)];
        mul_b = qq_r[mre_pkg::qb_sel(cmd.k)];
      end
      mre_pkg::ST_PMUL: begin
        mul_a = rm_r[cmd.k];
        mul_b = pv_r[mre_pkg::pj_sel(cmd.k)];
      end
      mre_pkg::ST_SQR: begin
        mul_a = cmd.k[0] ? rv_r : ru_r;
        mul_b = cmd.k[0] ? rv_r : ru_r;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    for (int i = 0; i < 9; i++) me[i] = SW'(m_r[i]);
    rmat_v[0] = sat32(ONE_S - ((me[0] + me[1]) <<< 1));
    rmat_v[1] = sat32((me[2] - me[3]) <<< 1);
    rmat_v[2] = sat32((me[4] + me[5]) <<< 1);
    rmat_v[3] = sat32((me[2] + me[3]) <<< 1);
    rmat_v[4] = sat32(ONE_S - ((me[6] + me[1]) <<< 1));
    rmat_v[5] = sat32((me[7] - me[8]) <<< 1);
    rmat_v[6] = sat32((me[4] - me[5]) <<< 1);
    rmat_v[7] = sat32((me[7] + me[8]) <<< 1);
    rmat_v[8] = sat32(ONE_S - ((me[6] + me[0]) <<< 1));
    for (int i = 0; i < 3; i++) begin
      cs_v[i] = sat32(me[3*i] + me[3*i+1] + me[3*i+2] + SW'(tv_r[i]));
    end
  end

  assign depth_zero = (cv_r[2] == 32'sd0);
  assign count_zero = (cnt_r == 32'd0);

  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_start = 1'b0;
    case (cmd.step)
      mre_pkg::ST_DIVU: begin
        div_num   = NUM_W'(abs32(cv_r[0])) << FRACTION_BITS;
        div_den   = abs32(cv_r[2]);
        div_start = cmd.go && !depth_zero;
      end
      mre_pkg::ST_DIVV: begin
        div_num   = NUM_W'(abs32(cv_r[1])) << FRACTION_BITS;
        div_den   = abs32(cv_r[2]);
        div_start = cmd.go;
      end
      mre_pkg::ST_FIN: begin
        div_num   = NUM_W'(sum_r);
        div_den   = cnt_r;
        div_start = cmd.go && !count_zero;
      end
      default: ;
    endcase
  end

  assign sqrt_start = (cmd.step == mre_pkg::ST_SQRT) && cmd.go;

  mre_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  mre_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .rad  (sq_r[0] + sq_r[1]),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      obs_u_r    <= in_item.obs_u;
      obs_v_r    <= in_item.obs_v;
      cam_base_r <= CAW'(CAW'(in_item.camera_index) * CAW'(mre_pkg::CAM_WORDS));
      pt_base_r  <= PAW'(PAW'(in_item.point_index) * PAW'(mre_pkg::PT_WORDS));
    end
    fetch_k_r <= cmd.k[2:0];
    if (fetch_v_r) begin
      if (fetch_k_r inside {[3'd0:3'd3]}) qq_r[fetch_k_r[1:0]] <= cam_rd_r;
      if (fetch_k_r inside {[3'd4:3'd6]}) tv_r[2'(fetch_k_r - 3'd4)] <= cam_rd_r;
      if (fetch_k_r inside {[3'd0:3'd2]}) pv_r[fetch_k_r[1:0]] <= pt_rd_r;
    end
    case (cmd.step)
      mre_pkg::ST_QMUL, mre_pkg::ST_PMUL: m_r[cmd.k] <= QW'(prod >>> FRACTION_BITS);
      mre_pkg::ST_RMAT: for (int i = 0; i < 9; i++) rm_r[i] <= rmat_v[i];
      mre_pkg::ST_CSUM: for (int i = 0; i < 3; i++) cv_r[i] <= cs_v[i];
      mre_pkg::ST_DIVU: if (div_done) nu_r <= proj(div_quo, cv_r[0][31] ^ cv_r[2][31]);
      mre_pkg::ST_DIVV: if (div_done) nv_r <= proj(div_quo, cv_r[1][31] ^ cv_r[2][31]);
      mre_pkg::ST_RESID: begin
        ru_r <= sub_sat(nu_r, obs_u_r);
        rv_r <= sub_sat(nv_r, obs_v_r);
      end
      mre_pkg::ST_SQR: sq_r[cmd.k[0]] <= prod;
      mre_pkg::ST_SQRT: if (sqrt_done) norm_r <= sqrt_root;
      mre_pkg::ST_FIN: begin
        if (div_done) mean_r <= (|div_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
      end
      mre_pkg::ST_OUT: begin
        out_r.mean_error        <= count_zero ? 32'd0 : mean_r;
        out_r.observation_count <= cnt_r;
        out_r.depth_fault       <= fault_r;
        out_r.empty_set         <= count_zero;
      end
      default: ;
    endcase
  end

  assign acc_n   = depth_zero ? 32'hFFFF_FFFF : norm_r;
  assign sum_ext = {1'b0, sum_r} + (mre_pkg::SUM_W + 1)'(acc_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fetch_v_r   <= 1'b0;
    end else begin
      fetch_v_r   <= (cmd.step == mre_pkg::ST_FETCH);
      out_valid_r <= (cmd.step == mre_pkg::ST_OUT);
      if (cmd.step == mre_pkg::ST_ACC) begin
        sum_r <= sum_ext[mre_pkg::SUM_W] ? '1 : sum_ext[mre_pkg::SUM_W-1:0];
        if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
        if (depth_zero) fault_r <= 1'b1;
      end else if (cmd.step == mre_pkg::ST_OUT) begin
        sum_r   <= '0;
        cnt_r   <= '0;
        fault_r <= 1'b0;
      end
    end
  end

  assign sts.obs_ok     = cam_ok && pt_ok;
  assign sts.depth_zero = depth_zero;
  assign sts.count_zero = count_zero;
  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sqrt_done;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

[hw/rtl/mre_ctrl.sv]
// Controller state machine sequencing the observation and finish steps.
`timescale 1ns / 1ps
`default_nettype none
module mre_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire mre_pkg::op_t     in_op,
  input  wire mre_pkg::status_t sts,
  output logic                  busy,
  output mre_pkg::cmd_t         cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_FETCH = 14'b00000000000010,
    S_QMUL  = 14'b00000000000100,
    S_RMAT  = 14'b00000000001000,
    S_PMUL  = 14'b00000000010000,
    S_CSUM  = 14'b00000000100000,
    S_DIVU  = 14'b00000001000000,
    S_DIVV  = 14'b00000010000000,
    S_RESID = 14'b00000100000000,
    S_SQR   = 14'b00001000000000,
    S_SQRT  = 14'b00010000000000,
    S_ACC   = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        k_nxt = 4'd0;
        if (start) begin
          if (in_op == mre_pkg::OP_OBS && sts.obs_ok) state_nxt = S_FETCH;
          else if (in_op == mre_pkg::OP_FINISH) state_nxt = S_FIN;
        end
      end
      S_FETCH: begin
        if (k_r == 4'd7) begin
          state_nxt = S_QMUL;
          k_nxt     = 4'd0;
        end else k_nxt = k_r + 4'd1;
      end
      S_QMUL: begin
        if (k_r == 4'd8) begin
          state_nxt = S_RMAT;
          k_nxt     = 4'd0;
        end else k_nxt = k_r + 4'd1;
      end
      S_RMAT: state_nxt = S_PMUL;
      S_PMUL: begin
        if (k_r == 4'd8) begin
          state_nxt = S_CSUM;
          k_nxt     = 4'd0;
        end else k_nxt = k_r + 4'd1;
      end
      S_CSUM: state_nxt = S_DIVU;
      S_DIVU: begin
        if (k_r == 4'd0 && sts.depth_zero) state_nxt = S_ACC;
        else begin
          k_nxt = 4'd1;
          if (sts.div_done) begin
            state_nxt = S_DIVV;
            k_nxt     = 4'd0;
          end
        end
      end
      S_DIVV: begin
        k_nxt = 4'd1;
        if (sts.div_done) begin
          state_nxt = S_RESID;
          k_nxt     = 4'd0;
        end
      end
      S_RESID: state_nxt = S_SQR;
      S_SQR: begin
        if (k_r == 4'd1) begin
          state_nxt = S_SQRT;
          k_nxt     = 4'd0;
        end else k_nxt = k_r + 4'd1;
      end
      S_SQRT: begin
        k_nxt = 4'd1;
        if (sts.sqrt_done) begin
          state_nxt = S_ACC;
          k_nxt     = 4'd0;
        end
      end
      S_ACC: state_nxt = S_IDLE;
      S_FIN: begin
        if (k_r == 4'd0 && sts.count_zero) state_nxt = S_OUT;
        else begin
          k_nxt = 4'd1;
          if (sts.div_done) begin
            state_nxt = S_OUT;
            k_nxt     = 4'd0;
          end
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: begin
        state_nxt = S_IDLE;
        k_nxt     = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 4'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    case (state_r)
      S_FETCH: cmd.step = mre_pkg::ST_FETCH;
      S_QMUL:  cmd.step = mre_pkg::ST_QMUL;
      S_RMAT:  cmd.step = mre_pkg::ST_RMAT;
      S_PMUL:  cmd.step = mre_pkg::ST_PMUL;
      S_CSUM:  cmd.step = mre_pkg::ST_CSUM;
      S_DIVU:  cmd.step = mre_pkg::ST_DIVU;
      S_DIVV:  cmd.step = mre_pkg::ST_DIVV;
      S_RESID: cmd.step = mre_pkg::ST_RESID;
      S_SQR:   cmd.step = mre_pkg::ST_SQR;
      S_SQRT:  cmd.step = mre_pkg::ST_SQRT;
      S_ACC:   cmd.step = mre_pkg::ST_ACC;
      S_FIN:   cmd.step = mre_pkg::ST_FIN;
      S_OUT:   cmd.step = mre_pkg::ST_OUT;
      default: cmd.step = mre_pkg::ST_NONE;
    endcase
    cmd.k  = k_r;
    cmd.go = (k_r == 4'd0);
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/mean_reprojection_error.sv]
// Top level: mean reprojection error accumulator, controller plus datapath.
// Loads never raise busy. An in-range observation holds busy through fetch, products,
// rotation, camera sum, two serial divisions, residual, squares, square root and
// accumulate; zero depth skips to accumulate. A finish holds busy through its division
// (none on an empty set) and output, then out_valid strobes; the receiver cannot stall.
// Synchronous active-low reset clears sum, count, fault and control, not the stores.
`timescale 1ns / 1ps
`default_nettype none
module mean_reprojection_error #(
  parameter int MAX_CAMERAS   = mre_pkg::MAX_CAMERAS_DEF,
  parameter int MAX_POINTS    = mre_pkg::MAX_POINTS_DEF,
  parameter int FRACTION_BITS = mre_pkg::FRACTION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire mre_pkg::in_item_t in_item,
  output logic                   out_valid,
  output mre_pkg::out_item_t     out_item
);

  mre_pkg::cmd_t    cmd;
  mre_pkg::status_t sts;
  logic             accept;

  assign accept = start && !busy;

  mre_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .in_op(in_item.op),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  mre_dp #(
    .MAX_CAMERAS  (MAX_CAMERAS),
    .MAX_POINTS   (MAX_POINTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
